### design/ogva_pkg.sv
// Package for the occupancy grid vote accumulator: opcodes, classes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ogva_pkg;
    localparam int MAP_WIDTH_DEF  = 256;
    localparam int MAP_HEIGHT_DEF = 256;
    localparam int LOCAL_SIZE_DEF = 256;
    localparam logic [7:0] VOTE_MAX = 8'd255;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [2:0] CV_TRAV = 3'd2;
    localparam logic [2:0] CV_OBST = 3'd3;
    localparam logic [2:0] CV_SLAM = 3'd4;

    localparam logic [1:0] CLS_UNKNOWN = 2'd0;
    localparam logic [1:0] CLS_TRAV    = 2'd1;
    localparam logic [1:0] CLS_OBST    = 2'd2;
    localparam logic [1:0] CLS_SLAM    = 2'd3;

    localparam logic [1:0] REG_STEP_COS = 2'd0;
    localparam logic [1:0] REG_STEP_SIN = 2'd1;
    localparam logic [1:0] REG_OFFSET_X = 2'd2;
    localparam logic [1:0] REG_OFFSET_Y = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_MUL, ST_SUM, ST_READ, ST_WRITE, ST_OUT
    } t_state;

    typedef struct packed {
        logic clr_en;      // write zero at clear address
        logic load;        // capture input beat
        logic mul_en;      // register products
        logic sum_en;      // register sums, issue read
        logic upd_en;      // modify counters and write back
        logic out_load;    // present result
    } t_cmd;

    typedef struct packed {
        logic clr_done;
    } t_stat;
endpackage
`default_nettype wire

### design/occupancy_grid_vote_accumulator_core.sv
// Occupancy grid vote accumulator, top level.
// Each input beat passes through capture, multiply, sum, RAM read, write and present
// steps; a new beat is not accepted until the result beat has been taken. Reset:
// synchronous active low; the RAM is then swept to zero, one entry per cycle
// (MAP_WIDTH*MAP_HEIGHT entries).
`timescale 1ns / 1ps
`default_nettype none
module occupancy_grid_vote_accumulator_core
    import ogva_pkg::*;
#(
    parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = MAP_HEIGHT_DEF,
    parameter int LOCAL_SIZE = LOCAL_SIZE_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [23:0] i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_opcode,
    input  wire  [7:0]  i_local_x,
    input  wire  [7:0]  i_local_y,
    input  wire  [2:0]  i_cell_value,
    input  wire  [7:0]  i_read_x,
    input  wire  [7:0]  i_read_y,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_cell_class,
    output logic [7:0]  o_trav_votes,
    output logic [7:0]  o_obst_votes,
    output logic [7:0]  o_slam_votes,
    output logic [7:0]  o_global_x,
    output logic [7:0]  o_global_y,
    output logic        o_out_of_range
);
    t_cmd  cmd;
    t_stat stat;

    // sequencer: clear sweep, then capture / multiply / sum / read / write / present
    ogva_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_out_ready(i_ready),
        .i_stat(stat), .o_in_ready(o_ready), .o_out_valid(o_valid), .o_cmd(cmd)
    );

    ogva_dp #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT), .LOCAL_SIZE(LOCAL_SIZE)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_opcode(i_opcode), .i_local_x(i_local_x), .i_local_y(i_local_y),
        .i_cell_value(i_cell_value), .i_read_x(i_read_x), .i_read_y(i_read_y),
        .o_cell_class(o_cell_class), .o_trav_votes(o_trav_votes),
        .o_obst_votes(o_obst_votes), .o_slam_votes(o_slam_votes),
        .o_global_x(o_global_x), .o_global_y(o_global_y),
        .o_out_of_range(o_out_of_range)
    );
endmodule
`default_nettype wire

### design/ogva_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ogva_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### design/ogva_ctrl.sv
// Controller FSM for the vote accumulator.
// Depends on ogva_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ogva_ctrl
    import ogva_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  wire   i_out_ready,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_CLEAR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (i_stat.clr_done) n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = ST_MUL;
            ST_MUL:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_READ;
            ST_READ:  n_state = ST_WRITE;
            ST_WRITE: n_state = ST_OUT;
            ST_OUT:   if (i_out_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr_en = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL:   o_cmd.mul_en = 1'b1;
            ST_SUM:   o_cmd.sum_en = 1'b1;
            ST_READ:  ;
            ST_WRITE: begin
                o_cmd.upd_en   = 1'b1;
                o_cmd.out_load = 1'b1;
            end
            ST_OUT:   o_out_valid = 1'b1;
            default:  ;
        endcase
    end
endmodule
`default_nettype wire

### design/ogva_dp.sv
// Datapath: coordinate transform, vote store, counter update and vote.
// Depends on ogva_pkg and ogva_ram.
`timescale 1ns / 1ps
`default_nettype none
module ogva_dp
    import ogva_pkg::*;
#(
    parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = MAP_HEIGHT_DEF,
    parameter int LOCAL_SIZE = LOCAL_SIZE_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [23:0] i_cfg_data,
    input  wire  [1:0]  i_opcode,
    input  wire  [7:0]  i_local_x,
    input  wire  [7:0]  i_local_y,
    input  wire  [2:0]  i_cell_value,
    input  wire  [7:0]  i_read_x,
    input  wire  [7:0]  i_read_y,
    output logic [1:0]  o_cell_class,
    output logic [7:0]  o_trav_votes,
    output logic [7:0]  o_obst_votes,
    output logic [7:0]  o_slam_votes,
    output logic [7:0]  o_global_x,
    output logic [7:0]  o_global_y,
    output logic        o_out_of_range
);
    localparam int XW    = $clog2(MAP_WIDTH);
    localparam int YW    = $clog2(MAP_HEIGHT);
    localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic signed [15:0] r_step_cos, r_step_sin;
    logic signed [23:0] r_offset_x, r_offset_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_cos <= 16'sd4096;
            r_step_sin <= '0;
            r_offset_x <= '0;
            r_offset_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_STEP_COS: r_step_cos <= i_cfg_data[15:0];
                REG_STEP_SIN: r_step_sin <= i_cfg_data[15:0];
                REG_OFFSET_X: r_offset_x <= i_cfg_data;
                REG_OFFSET_Y: r_offset_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clear sweep counter
    logic [AW:0] r_clr_addr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)          r_clr_addr <= '0;
        else if (i_cmd.clr_en) r_clr_addr <= r_clr_addr + 1'b1;
    end
    assign o_stat.clr_done = (r_clr_addr == (AW+1)'(DEPTH - 1));

    // captured beat
    logic [1:0] r_op;
    logic [7:0] r_lx, r_ly, r_rx, r_ry;
    logic [2:0] r_cv;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode; r_lx <= i_local_x; r_ly <= i_local_y;
            r_cv <= i_cell_value; r_rx <= i_read_x; r_ry <= i_read_y;
        end
    end

    // products: 9b signed x 16b signed
    logic signed [24:0] r_xc, r_ys, r_xs, r_yc;
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_xc <= $signed({1'b0, r_lx}) * r_step_cos;
            r_ys <= $signed({1'b0, r_ly}) * r_step_sin;
            r_xs <= $signed({1'b0, r_lx}) * r_step_sin;
            r_yc <= $signed({1'b0, r_ly}) * r_step_cos;
        end
    end

    logic signed [26:0] sum_x, sum_y;
    logic        [26:0] mag_x, mag_y;
    logic        [14:0] cx, cy;
    logic               oor;
    logic        [7:0]  gx8, gy8;
    always_comb begin
        sum_x = 27'(r_offset_x) + 27'(r_xc) - 27'(r_ys);
        sum_y = 27'(r_offset_y) + 27'(r_xs) + 27'(r_yc);
        mag_x = sum_x[26] ? 27'(-sum_x) : 27'(sum_x);
        mag_y = sum_y[26] ? 27'(-sum_y) : 27'(sum_y);
        cx = mag_x[26:12];
        cy = mag_y[26:12];
        if (r_op == OP_READ) begin
            oor = (32'(r_rx) >= 32'(MAP_WIDTH)) || (32'(r_ry) >= 32'(MAP_HEIGHT));
            gx8 = r_rx; gy8 = r_ry;
        end else begin
            // negative with magnitude >= 1 cell is outside; truncation gives 0
            oor = (sum_x[26] && cx != '0) || (sum_y[26] && cy != '0)
                || (32'(cx) >= 32'(MAP_WIDTH)) || (32'(cy) >= 32'(MAP_HEIGHT))
                || (32'(r_lx) >= 32'(LOCAL_SIZE)) || (32'(r_ly) >= 32'(LOCAL_SIZE));
            gx8 = cx[7:0]; gy8 = cy[7:0];
        end
    end

    logic [XW-1:0] r_gx;
    logic [YW-1:0] r_gy;
    logic [7:0]    r_gx8, r_gy8;
    logic          r_oor;
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_en) begin
            r_oor <= oor || (r_op == OP_NOP);
            r_gx8 <= gx8; r_gy8 <= gy8;
            r_gx  <= (r_op == OP_READ) ? XW'(r_rx) : cx[XW-1:0];
            r_gy  <= (r_op == OP_READ) ? YW'(r_ry) : cy[YW-1:0];
        end
    end

    logic [AW-1:0] addr;
    assign addr = AW'(32'(r_gy) * MAP_WIDTH + 32'(r_gx));

    logic [23:0] rdata, wdata;
    logic        we;
    logic [AW-1:0] waddr;
    ogva_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(addr),
        .o_rdata(rdata)
    );

    logic [7:0] tr, ob, sl;
    logic       bump;
    logic [1:0] cls;
    always_comb begin
        tr = rdata[7:0]; ob = rdata[15:8]; sl = rdata[23:16];
        bump = (r_op == OP_ADD || r_op == OP_REMOVE) && !r_oor;
        if (bump) begin
            case (r_cv)
                CV_TRAV: tr = (r_op == OP_ADD) ? ((tr != VOTE_MAX) ? tr + 8'd1 : tr)
                                               : ((tr != 8'd0) ? tr - 8'd1 : tr);
                CV_OBST: ob = (r_op == OP_ADD) ? ((ob != VOTE_MAX) ? ob + 8'd1 : ob)
                                               : ((ob != 8'd0) ? ob - 8'd1 : ob);
                CV_SLAM: sl = (r_op == OP_ADD) ? ((sl != VOTE_MAX) ? sl + 8'd1 : sl)
                                               : ((sl != 8'd0) ? sl - 8'd1 : sl);
                default: ;
            endcase
        end
        if ({1'b0, ob} + {1'b0, sl} > {1'b0, tr}) cls = (ob > sl) ? CLS_OBST : CLS_SLAM;
        else cls = (tr != 8'd0) ? CLS_TRAV : CLS_UNKNOWN;
        we    = i_cmd.clr_en || (i_cmd.upd_en && bump);
        waddr = i_cmd.clr_en ? r_clr_addr[AW-1:0] : addr;
        wdata = i_cmd.clr_en ? 24'd0 : {sl, ob, tr};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_of_range <= r_oor && (r_op != OP_NOP);
            o_cell_class   <= r_oor ? CLS_UNKNOWN : cls;
            o_trav_votes   <= r_oor ? 8'd0 : tr;
            o_obst_votes   <= r_oor ? 8'd0 : ob;
            o_slam_votes   <= r_oor ? 8'd0 : sl;
            o_global_x     <= r_oor ? 8'd0 : r_gx8;
            o_global_y     <= r_oor ? 8'd0 : r_gy8;
        end
    end
endmodule
`default_nettype wire

### design/ogva_checker.sv
// Port-level checker for the vote accumulator, bound to the top level.
// Depends on ogva_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ogva_checker
    import ogva_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_ready,
    input wire       o_valid,
    input wire       i_ready,
    input wire       i_valid,
    input wire       o_out_of_range,
    input wire [1:0] o_cell_class,
    input wire [7:0] o_trav_votes
);
    // one item in flight: never ready while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready while result pending");
    // an accepted beat is never followed immediately by a result
    a_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_valid) else $error("early result");
    // out-of-range results report unknown class and zero traversable votes
    a_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (o_cell_class == CLS_UNKNOWN && o_trav_votes == 8'd0))
        else $error("out of range result not cleared");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_cell_class)))
        else $error("result dropped while stalled");
endmodule

bind occupancy_grid_vote_accumulator_core ogva_checker u_ogva_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .o_valid(o_valid),
    .i_ready(i_ready), .i_valid(i_valid), .o_out_of_range(o_out_of_range),
    .o_cell_class(o_cell_class), .o_trav_votes(o_trav_votes)
);
`default_nettype wire
